// ===== rtl/rso_pkg.sv =====
// ----------------------------------------------------------------------------
// rso_pkg
// Shared types and constants for the orbit stepper: adder request and
// response, result codes and fixed field widths.
// ----------------------------------------------------------------------------
package rso_pkg;

    // Width of the shared adder, wide enough for clock + mex + 1
    localparam int ARITH_W = 33;
    // Step clock, run lengths and horizon
    localparam int CNT_W   = 31;
    // Bitmap word
    localparam int WORD_W  = 64;
    localparam int BIT_W   = 6;
    // Output field widths
    localparam int VALUE_OUT_W = 26;
    localparam int MEX_OUT_W   = 27;

    localparam logic [CNT_W-1:0] HORIZON_RESET = 31'd100000000;
    localparam logic [BIT_W-1:0] LAST_BIT      = 6'd63;

    // Step kind codes
    localparam logic [1:0] KIND_SUB     = 2'd0;
    localparam logic [1:0] KIND_ADD     = 2'd1;
    localparam logic [1:0] KIND_BLOCKED = 2'd2;

    // Candidate class codes
    localparam logic [1:0] CLS_NONE  = 2'd0;
    localparam logic [1:0] CLS_BELOW = 2'd1;
    localparam logic [1:0] CLS_EQUAL = 2'd2;
    localparam logic [1:0] CLS_ABOVE = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_STEP     = 2'd0;
    localparam logic [1:0] STAT_HORIZON  = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW = 2'd2;

    // Adder request: sum = a + (inv_b ? ~b : b) + cin
    typedef struct packed {
        logic [ARITH_W-1:0] a;
        logic [ARITH_W-1:0] b;
        logic               inv_b;
        logic               cin;
    } alu_req_t;

    // Adder response; for a subtract, carry set means a >= b
    typedef struct packed {
        logic [ARITH_W-1:0] sum;
        logic               carry;
        logic               zero;
    } alu_rsp_t;

endpackage

// ===== rtl/recaman_orbit_stepper.sv =====
// ----------------------------------------------------------------------------
// recaman_orbit_stepper
// Steps the Recaman orbit one term per advance beat, keeping a visited
// bitmap and the mex, and reports step, cone and run tracking per beat.
// ----------------------------------------------------------------------------
//  channel  | signals                          | beat
//  ---------+----------------------------------+-----------------------------
//  input    | in_valid, in_ready, advance      | one step request
//  output   | out_valid, out_ready, 12 fields  | one step result
//  config   | cfg_we, cfg_wdata                | horizon_steps write
//
// After reset a clearing pass writes each of the SEEN_WORDS bitmap words with
// in_ready low. All arithmetic of a beat then runs on one shared adder: a halted
// block answers from the clock state, a horizon stop after the horizon check and
// a store overflow after the bound check; a subtraction or an addition then scans
// for the mex, word by word and bit by bit inside a word, up to the store end.
// in_ready is high only between beats; a stalled output holds the sequencer.
// ----------------------------------------------------------------------------
module recaman_orbit_stepper
    import rso_pkg::*;
#(
    parameter int SEEN_WORDS = 1048576
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config
    input  logic                   cfg_we,
    input  logic [CNT_W-1:0]       cfg_wdata,
    // input channel
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   advance,
    // output channel
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [CNT_W-1:0]       step_clock,
    output logic [VALUE_OUT_W-1:0] new_value,
    output logic [1:0]             step_kind,
    output logic [1:0]             candidate_class,
    output logic                   cone_outside,
    output logic [VALUE_OUT_W-1:0] cone_excess,
    output logic [CNT_W-1:0]       current_run,
    output logic [CNT_W-1:0]       closed_run_length,
    output logic [CNT_W-1:0]       closed_run_start,
    output logic [MEX_OUT_W-1:0]   mex_after,
    output logic [CNT_W-1:0]       longest_run_so_far,
    output logic [1:0]             status
);

    localparam int ADDR_W = $clog2(SEEN_WORDS);
    localparam int VAL_W  = ADDR_W + BIT_W;
    localparam int MEX_W  = VAL_W + 1;
    localparam int PAD_V  = ARITH_W - VAL_W;
    localparam int PAD_M  = ARITH_W - MEX_W;
    localparam int PAD_C  = ARITH_W - CNT_W;
    localparam logic [ARITH_W-1:0] STORE_LIMIT = ARITH_W'(SEEN_WORDS * 64);
    localparam logic [ADDR_W-1:0]  LAST_ADDR   = ADDR_W'(SEEN_WORDS - 1);
    localparam logic [MEX_W-1:0]   MEX_RESET   = MEX_W'(1);

    // Sequencer states
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_CLK  = 4'd2;
    localparam logic [3:0] S_HOR  = 4'd3;
    localparam logic [3:0] S_POS  = 4'd4;
    localparam logic [3:0] S_CLS  = 4'd5;
    localparam logic [3:0] S_LOOK = 4'd6;
    localparam logic [3:0] S_EXT  = 4'd7;
    localparam logic [3:0] S_OVF  = 4'd8;
    localparam logic [3:0] S_AWR  = 4'd9;
    localparam logic [3:0] S_RMAX = 4'd10;
    localparam logic [3:0] S_MRD  = 4'd11;
    localparam logic [3:0] S_MCHK = 4'd12;
    localparam logic [3:0] S_EMIT = 4'd13;

    // Control and orbit state
    logic [3:0]         state_reg, state_next;
    logic [ADDR_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [VAL_W-1:0]   orbit_reg, orbit_next;
    logic [CNT_W-1:0]   step_cnt_reg, step_cnt_next;
    logic [MEX_W-1:0]   mex_reg, mex_next;
    logic [CNT_W-1:0]   run_start_reg, run_start_next;
    logic [CNT_W-1:0]   run_count_reg, run_count_next;
    logic [CNT_W-1:0]   longest_reg, longest_next;
    logic               finished_reg, finished_next;
    logic [CNT_W-1:0]   horizon_reg;
    logic               out_valid_reg, out_valid_next;

    // Per-step working registers
    logic [CNT_W-1:0]   clk_reg, clk_next;
    logic [VAL_W-1:0]   cand_reg, cand_next;
    logic               pos_reg, pos_next;
    logic [1:0]         cls_reg, cls_next;
    logic [ARITH_W-1:0] sum_reg, sum_next;

    // Pending result fields
    logic [CNT_W-1:0]       res_clock_reg, res_clock_next;
    logic [VAL_W-1:0]       res_value_reg, res_value_next;
    logic [1:0]             res_kind_reg, res_kind_next;
    logic                   res_ext_reg, res_ext_next;
    logic [VALUE_OUT_W-1:0] res_excess_reg, res_excess_next;
    logic [CNT_W-1:0]       res_clen_reg, res_clen_next;
    logic [CNT_W-1:0]       res_cstart_reg, res_cstart_next;
    logic [1:0]             res_status_reg, res_status_next;
    logic                   out_load;

    // Output register
    logic [CNT_W-1:0]       step_clock_reg;
    logic [VALUE_OUT_W-1:0] new_value_reg;
    logic [1:0]             step_kind_reg;
    logic [1:0]             cand_class_reg;
    logic                   cone_ext_reg;
    logic [VALUE_OUT_W-1:0] cone_excess_reg;
    logic [CNT_W-1:0]       current_run_reg;
    logic [CNT_W-1:0]       closed_len_reg;
    logic [CNT_W-1:0]       closed_start_reg;
    logic [MEX_OUT_W-1:0]   mex_after_reg;
    logic [CNT_W-1:0]       longest_out_reg;
    logic [1:0]             status_reg;

    // Shared adder and bitmap ports
    alu_req_t          alu_req;
    alu_rsp_t          alu_rsp;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [WORD_W-1:0] rd_data;

    // Resizing helpers for output fields
    logic [VAL_W+VALUE_OUT_W-1:0] value_ext;
    logic [MEX_W+MEX_OUT_W-1:0]   mex_ext;
    logic                         cand_seen;
    logic                         mex_bit;
    logic                         mex_word_full;

    assign value_ext     = {{VALUE_OUT_W{1'b0}}, res_value_reg};
    assign mex_ext       = {{MEX_OUT_W{1'b0}}, mex_reg};
    assign cand_seen     = rd_data[cand_reg[BIT_W-1:0]];
    assign mex_bit       = rd_data[mex_reg[BIT_W-1:0]];
    assign mex_word_full = (mex_reg[BIT_W-1:0] == '0) && (&rd_data);
    assign out_load      = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    rso_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    rso_seen_mem
    #(
        .DEPTH  (SEEN_WORDS),
        .ADDR_W (ADDR_W)
    )
    u_seen_mem
    (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (rd_data)
    );

    assign in_ready = (state_reg == S_IDLE);

    // Sequencer and datapath
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        orbit_next      = orbit_reg;
        step_cnt_next   = step_cnt_reg;
        mex_next        = mex_reg;
        run_start_next  = run_start_reg;
        run_count_next  = run_count_reg;
        longest_next    = longest_reg;
        finished_next   = finished_reg;
        clk_next        = clk_reg;
        cand_next       = cand_reg;
        pos_next        = pos_reg;
        cls_next        = cls_reg;
        sum_next        = sum_reg;
        res_clock_next  = res_clock_reg;
        res_value_next  = res_value_reg;
        res_kind_next   = res_kind_reg;
        res_ext_next    = res_ext_reg;
        res_excess_next = res_excess_reg;
        res_clen_next   = res_clen_reg;
        res_cstart_next = res_cstart_reg;
        res_status_next = res_status_reg;
        alu_req         = '0;
        mem_we          = 1'b0;
        mem_waddr       = clr_addr_reg;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = cand_reg[VAL_W-1:BIT_W];

        case (state_reg)
            // Clearing pass; word zero starts with value zero visited
            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (clr_addr_reg == '0) ? WORD_W'(1) : '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (in_valid && advance)
                begin
                    state_next = S_CLK;
                end
            end

            // Acting clock; a halted block answers at once
            S_CLK:
            begin
                alu_req.a   = {{PAD_C{1'b0}}, step_cnt_reg};
                alu_req.cin = 1'b1;
                clk_next    = alu_rsp.sum[CNT_W-1:0];
                if (finished_reg)
                begin
                    res_clock_next  = alu_rsp.sum[CNT_W-1:0];
                    res_value_next  = orbit_reg;
                    res_kind_next   = KIND_SUB;
                    cls_next        = CLS_NONE;
                    res_ext_next    = 1'b0;
                    res_excess_next = '0;
                    res_clen_next   = '0;
                    res_cstart_next = '0;
                    res_status_next = STAT_OVERFLOW;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_HOR;
                end
            end

            // Horizon check; the open run is reported as censored
            S_HOR:
            begin
                alu_req.a     = {{PAD_C{1'b0}}, step_cnt_reg};
                alu_req.b     = {{PAD_C{1'b0}}, horizon_reg};
                alu_req.inv_b = 1'b1;
                alu_req.cin   = 1'b1;
                if (alu_rsp.carry)
                begin
                    res_clock_next  = step_cnt_reg;
                    res_value_next  = orbit_reg;
                    res_kind_next   = KIND_SUB;
                    cls_next        = CLS_NONE;
                    res_ext_next    = 1'b0;
                    res_excess_next = '0;
                    res_clen_next   = run_count_reg;
                    res_cstart_next = (run_count_reg != '0) ? run_start_reg : '0;
                    res_status_next = STAT_HORIZON;
                    run_count_next  = '0;
                    state_next      = S_EMIT;
                end
                else
                begin
                    state_next = S_POS;
                end
            end

            // Candidate = value - clock, positive only if value > clock
            S_POS:
            begin
                alu_req.a     = {{PAD_V{1'b0}}, orbit_reg};
                alu_req.b     = {{PAD_C{1'b0}}, clk_reg};
                alu_req.inv_b = 1'b1;
                alu_req.cin   = 1'b1;
                cand_next     = alu_rsp.sum[VAL_W-1:0];
                pos_next      = alu_rsp.carry && !alu_rsp.zero;
                state_next    = S_CLS;
            end

            // Class against mex, and fetch the candidate's word
            S_CLS:
            begin
                alu_req.a     = {{PAD_V{1'b0}}, cand_reg};
                alu_req.b     = {{PAD_M{1'b0}}, mex_reg};
                alu_req.inv_b = 1'b1;
                alu_req.cin   = 1'b1;
                mem_re        = 1'b1;
                mem_raddr     = cand_reg[VAL_W-1:BIT_W];
                if (!pos_reg)
                begin
                    cls_next = CLS_NONE;
                end
                else if (!alu_rsp.carry)
                begin
                    cls_next = CLS_BELOW;
                end
                else if (alu_rsp.zero)
                begin
                    cls_next = CLS_EQUAL;
                end
                else
                begin
                    cls_next = CLS_ABOVE;
                end
                state_next = S_LOOK;
            end

            // Subtract if free: cone bound; else the addition landing
            S_LOOK:
            begin
                if (pos_reg && !cand_seen)
                begin
                    alu_req.a     = {{PAD_C{1'b0}}, clk_reg};
                    alu_req.b     = {{PAD_M{1'b0}}, mex_reg};
                    alu_req.cin   = 1'b1;
                    res_kind_next = KIND_SUB;
                    state_next    = S_EXT;
                end
                else
                begin
                    alu_req.a     = {{PAD_V{1'b0}}, orbit_reg};
                    alu_req.b     = {{PAD_C{1'b0}}, clk_reg};
                    res_kind_next = pos_reg ? KIND_BLOCKED : KIND_ADD;
                    state_next    = S_OVF;
                end
                sum_next = alu_rsp.sum;
            end

            // Subtraction: cone class, mark landing, close the run
            S_EXT:
            begin
                alu_req.a       = {{PAD_V{1'b0}}, cand_reg};
                alu_req.b       = sum_reg;
                alu_req.inv_b   = 1'b1;
                alu_req.cin     = 1'b1;
                res_ext_next    = alu_rsp.carry;
                res_excess_next = alu_rsp.carry ? alu_rsp.sum[VALUE_OUT_W-1:0] : '0;
                mem_we          = 1'b1;
                mem_waddr       = cand_reg[VAL_W-1:BIT_W];
                mem_wdata       = rd_data | (WORD_W'(1) << cand_reg[BIT_W-1:0]);
                res_clock_next  = clk_reg;
                res_value_next  = cand_reg;
                res_clen_next   = run_count_reg;
                res_cstart_next = (run_count_reg != '0) ? run_start_reg : '0;
                res_status_next = STAT_STEP;
                run_count_next  = '0;
                orbit_next      = cand_reg;
                step_cnt_next   = clk_reg;
                state_next      = S_MRD;
            end

            // Addition: store bound check, then fetch the landing word
            S_OVF:
            begin
                alu_req.a       = sum_reg;
                alu_req.b       = STORE_LIMIT;
                alu_req.inv_b   = 1'b1;
                alu_req.cin     = 1'b1;
                res_clock_next  = clk_reg;
                res_ext_next    = 1'b0;
                res_excess_next = '0;
                res_clen_next   = '0;
                res_cstart_next = '0;
                if (alu_rsp.carry)
                begin
                    finished_next   = 1'b1;
                    res_value_next  = '0;
                    res_status_next = STAT_OVERFLOW;
                    state_next      = S_EMIT;
                end
                else
                begin
                    mem_re          = 1'b1;
                    mem_raddr       = sum_reg[VAL_W-1:BIT_W];
                    orbit_next      = sum_reg[VAL_W-1:0];
                    step_cnt_next   = clk_reg;
                    res_value_next  = sum_reg[VAL_W-1:0];
                    res_status_next = STAT_STEP;
                    state_next      = S_AWR;
                end
            end

            // Mark landing and extend the run
            S_AWR:
            begin
                mem_we         = 1'b1;
                mem_waddr      = orbit_reg[VAL_W-1:BIT_W];
                mem_wdata      = rd_data | (WORD_W'(1) << orbit_reg[BIT_W-1:0]);
                alu_req.a      = {{PAD_C{1'b0}}, run_count_reg};
                alu_req.cin    = 1'b1;
                run_count_next = alu_rsp.sum[CNT_W-1:0];
                if (run_count_reg == '0)
                begin
                    run_start_next = clk_reg;
                end
                state_next = S_RMAX;
            end

            // Running maximum of run length
            S_RMAX:
            begin
                alu_req.a     = {{PAD_C{1'b0}}, longest_reg};
                alu_req.b     = {{PAD_C{1'b0}}, run_count_reg};
                alu_req.inv_b = 1'b1;
                alu_req.cin   = 1'b1;
                if (!alu_rsp.carry)
                begin
                    longest_next = run_count_reg;
                end
                state_next = S_MRD;
            end

            // Mex scan: stop at the store end, else fetch the mex word
            S_MRD:
            begin
                alu_req.a     = {{PAD_M{1'b0}}, mex_reg};
                alu_req.b     = STORE_LIMIT;
                alu_req.inv_b = 1'b1;
                alu_req.cin   = 1'b1;
                if (alu_rsp.carry)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = mex_reg[VAL_W-1:BIT_W];
                    state_next = S_MCHK;
                end
            end

            // Mex scan: skip full words, walk bits inside a word
            S_MCHK:
            begin
                alu_req.a = {{PAD_M{1'b0}}, mex_reg};
                if (mex_word_full)
                begin
                    alu_req.b  = ARITH_W'(WORD_W);
                    mex_next   = alu_rsp.sum[MEX_W-1:0];
                    state_next = S_MRD;
                end
                else if (!mex_bit)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    alu_req.cin = 1'b1;
                    mex_next    = alu_rsp.sum[MEX_W-1:0];
                    if (mex_reg[BIT_W-1:0] == LAST_BIT)
                    begin
                        state_next = S_MRD;
                    end
                end
            end

            S_EMIT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_addr_reg  <= '0;
            orbit_reg     <= '0;
            step_cnt_reg  <= '0;
            mex_reg       <= MEX_RESET;
            run_start_reg <= '0;
            run_count_reg <= '0;
            longest_reg   <= '0;
            finished_reg  <= 1'b0;
            horizon_reg   <= HORIZON_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            orbit_reg     <= orbit_next;
            step_cnt_reg  <= step_cnt_next;
            mex_reg       <= mex_next;
            run_start_reg <= run_start_next;
            run_count_reg <= run_count_next;
            longest_reg   <= longest_next;
            finished_reg  <= finished_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                horizon_reg <= cfg_wdata;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge clk)
    begin
        clk_reg        <= clk_next;
        cand_reg       <= cand_next;
        pos_reg        <= pos_next;
        cls_reg        <= cls_next;
        sum_reg        <= sum_next;
        res_clock_reg  <= res_clock_next;
        res_value_reg  <= res_value_next;
        res_kind_reg   <= res_kind_next;
        res_ext_reg    <= res_ext_next;
        res_excess_reg <= res_excess_next;
        res_clen_reg   <= res_clen_next;
        res_cstart_reg <= res_cstart_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            step_clock_reg   <= res_clock_reg;
            new_value_reg    <= value_ext[VALUE_OUT_W-1:0];
            step_kind_reg    <= res_kind_reg;
            cand_class_reg   <= cls_reg;
            cone_ext_reg     <= res_ext_reg;
            cone_excess_reg  <= res_excess_reg;
            current_run_reg  <= run_count_reg;
            closed_len_reg   <= res_clen_reg;
            closed_start_reg <= res_cstart_reg;
            mex_after_reg    <= mex_ext[MEX_OUT_W-1:0];
            longest_out_reg  <= longest_reg;
            status_reg       <= res_status_reg;
        end
    end

    assign out_valid          = out_valid_reg;
    assign step_clock         = step_clock_reg;
    assign new_value          = new_value_reg;
    assign step_kind          = step_kind_reg;
    assign candidate_class    = cand_class_reg;
    assign cone_outside       = cone_ext_reg;
    assign cone_excess        = cone_excess_reg;
    assign current_run        = current_run_reg;
    assign closed_run_length  = closed_len_reg;
    assign closed_run_start   = closed_start_reg;
    assign mex_after          = mex_after_reg;
    assign longest_run_so_far = longest_out_reg;
    assign status             = status_reg;

endmodule

// ===== rtl/rso_alu.sv =====
// ----------------------------------------------------------------------------
// rso_alu
// Shared add / subtract / compare unit used by the arithmetic states of the sequencer.
// ----------------------------------------------------------------------------
module rso_alu
    import rso_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [ARITH_W-1:0] b_op;
    logic [ARITH_W:0]   full_sum;

    // Two's complement subtract when b is inverted and carry-in is set
    assign b_op     = req.inv_b ? ~req.b : req.b;
    assign full_sum = {1'b0, req.a} + {1'b0, b_op} + {{ARITH_W{1'b0}}, req.cin};

    assign rsp.sum   = full_sum[ARITH_W-1:0];
    assign rsp.carry = full_sum[ARITH_W];
    assign rsp.zero  = (full_sum[ARITH_W-1:0] == '0);

endmodule

// ===== rtl/rso_seen_mem.sv =====
// ----------------------------------------------------------------------------
// rso_seen_mem
// Visited bitmap store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rso_seen_mem
    import rso_pkg::*;
#(
    parameter int DEPTH  = 1048576,
    parameter int ADDR_W = 20
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== verif/recaman_orbit_stepper_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// recaman_orbit_stepper_test
// Self-checking bench for the orbit stepper. A directed table walks the first
// orbit terms, ignored beats and horizon stop and resume. Random phases follow
// with mixed horizons. Every result beat is checked field by field against its
// table row or an in-bench orbit tracker with its own bitmap, mex and run state.
// ----------------------------------------------------------------------------
module recaman_orbit_stepper_test
    import rso_pkg::*;
();

    // A small store keeps the clearing pass short
    localparam int STORE_WORDS  = 1024;
    localparam int STORE_BITS   = STORE_WORDS * WORD_W;
    localparam int SETTLE_WAIT  = 32;
    localparam int QUIET_LIMIT  = 20000;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_AFTER   = 300;
    localparam int PHASE_STEPS  = 205;
    localparam logic [CNT_W-1:0] HORIZON_MAX = 31'd2000000000;
    localparam logic [CNT_W-1:0] HORIZON_MIN = 31'd1;

    typedef struct packed {
        logic [CNT_W-1:0]       step_clock;
        logic [VALUE_OUT_W-1:0] new_value;
        logic [1:0]             step_kind;
        logic [1:0]             candidate_class;
        logic                   cone_outside;
        logic [VALUE_OUT_W-1:0] cone_excess;
        logic [CNT_W-1:0]       current_run;
        logic [CNT_W-1:0]       closed_run_length;
        logic [CNT_W-1:0]       closed_run_start;
        logic [MEX_OUT_W-1:0]   mex_after;
        logic [CNT_W-1:0]       longest_run_so_far;
        logic [1:0]             status;
    } orbit_result_t;

    // One directed beat, with an optional horizon write ahead of it
    typedef struct {
        bit               set_horizon;
        logic [CNT_W-1:0] horizon_val;
        bit               adv;
        bit               typed;
        orbit_result_t    want;
    } plan_row_t;

    bit clk;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CNT_W-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic advance = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [CNT_W-1:0]       step_clock;
    logic [VALUE_OUT_W-1:0] new_value;
    logic [1:0]             step_kind;
    logic [1:0]             candidate_class;
    logic                   cone_outside;
    logic [VALUE_OUT_W-1:0] cone_excess;
    logic [CNT_W-1:0]       current_run;
    logic [CNT_W-1:0]       closed_run_length;
    logic [CNT_W-1:0]       closed_run_start;
    logic [MEX_OUT_W-1:0]   mex_after;
    logic [CNT_W-1:0]       longest_run_so_far;
    logic [1:0]             status;

    // Orbit tracker state
    bit                   visited [STORE_BITS];
    logic [VALUE_OUT_W-1:0] orbit_now  = '0;
    logic [CNT_W-1:0]     steps_done = '0;
    logic [MEX_OUT_W-1:0] mex_now    = 27'd1;
    logic [CNT_W-1:0]     open_run_from = '0;
    logic [CNT_W-1:0]     run_len    = '0;
    logic [CNT_W-1:0]     run_best   = '0;
    bit                   halted     = 1'b0;
    logic [CNT_W-1:0]     horizon    = HORIZON_RESET;

    orbit_result_t pending_results [$];
    plan_row_t     plan_rows [$];
    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  quiet_cycles   = 0;
    longint cycle_count = 0;

    string field_names [12] = '{"step_clock", "new_value", "step_kind", "candidate_class",
        "cone_outside", "cone_excess", "current_run", "closed_run_length",
        "closed_run_start", "mex_after", "longest_run_so_far", "status"};

    recaman_orbit_stepper #(
        .SEEN_WORDS(STORE_WORDS)
    ) dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .advance            (advance),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .step_clock         (step_clock),
        .new_value          (new_value),
        .step_kind          (step_kind),
        .candidate_class    (candidate_class),
        .cone_outside       (cone_outside),
        .cone_excess        (cone_excess),
        .current_run        (current_run),
        .closed_run_length  (closed_run_length),
        .closed_run_start   (closed_run_start),
        .mex_after          (mex_after),
        .longest_run_so_far (longest_run_so_far),
        .status             (status)
    );

    // Clock, 10 ns period
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Step the mex past every visited value
    function automatic void bump_mex();
        while (mex_now < STORE_BITS && visited[mex_now])
            mex_now++;
    endfunction

    // One advance beat applied to the tracker; returns the expected result
    function automatic orbit_result_t orbit_step();
        longint unsigned c_n;
        longint unsigned cand;
        longint unsigned bound;
        longint unsigned landing;
        bit has_cand;
        orbit_result_t r;
        r = '0;
        c_n = longint'(steps_done) + 1;
        if (halted)
        begin
            r.step_clock = c_n[CNT_W-1:0];
            r.new_value  = orbit_now;
            r.status     = STAT_OVERFLOW;
        end
        else if (steps_done >= horizon)
        begin
            // censored run closes at the horizon
            r.step_clock        = steps_done;
            r.new_value         = orbit_now;
            r.closed_run_length = run_len;
            r.closed_run_start  = (run_len != 0) ? open_run_from : '0;
            r.status            = STAT_HORIZON;
            run_len             = '0;
        end
        else
        begin
            has_cand = orbit_now > c_n;
            cand     = has_cand ? orbit_now - c_n : 0;
            if (has_cand)
                r.candidate_class = (cand < mex_now) ? CLS_BELOW :
                                    (cand == mex_now) ? CLS_EQUAL : CLS_ABOVE;
            r.step_clock = c_n[CNT_W-1:0];
            if (has_cand && !visited[cand])
            begin
                bound               = c_n + 1 + mex_now;
                r.step_kind         = KIND_SUB;
                r.cone_outside      = cand >= bound;
                r.cone_excess       = (cand >= bound) ? VALUE_OUT_W'(cand - bound) : '0;
                r.closed_run_length = run_len;
                r.closed_run_start  = (run_len != 0) ? open_run_from : '0;
                run_len             = '0;
                orbit_now           = VALUE_OUT_W'(cand);
                steps_done          = c_n[CNT_W-1:0];
                visited[cand]       = 1'b1;
                bump_mex();
                r.new_value         = orbit_now;
            end
            else
            begin
                r.step_kind = has_cand ? KIND_BLOCKED : KIND_ADD;
                landing     = orbit_now + c_n;
                if (landing >= STORE_BITS)
                begin
                    // landing outside the store: halt, state kept
                    halted   = 1'b1;
                    r.status = STAT_OVERFLOW;
                end
                else
                begin
                    if (run_len == 0)
                        open_run_from = c_n[CNT_W-1:0];
                    run_len++;
                    if (run_len > run_best)
                        run_best = run_len;
                    orbit_now        = VALUE_OUT_W'(landing);
                    steps_done       = c_n[CNT_W-1:0];
                    visited[landing] = 1'b1;
                    bump_mex();
                    r.new_value      = orbit_now;
                end
            end
        end
        r.current_run        = run_len;
        r.mex_after          = mex_now;
        r.longest_run_so_far = run_best;
        return r;
    endfunction

    function automatic orbit_result_t known_result(int sc, int nv, logic [1:0] kind,
        logic [1:0] cls, int ext, int exc, int cur, int clen, int cst, int mex, int lng,
        logic [1:0] st);
        orbit_result_t r;
        r = {CNT_W'(sc), VALUE_OUT_W'(nv), kind, cls, 1'(ext), VALUE_OUT_W'(exc),
             CNT_W'(cur), CNT_W'(clen), CNT_W'(cst), MEX_OUT_W'(mex), CNT_W'(lng), st};
        return r;
    endfunction

    // Append one row to the directed table
    function automatic void add_row(bit set_h, logic [CNT_W-1:0] hval, bit adv, bit typed,
        orbit_result_t want);
        plan_row_t row;
        row.set_horizon = set_h;
        row.horizon_val = hval;
        row.adv         = adv;
        row.typed       = typed;
        row.want        = want;
        plan_rows.insert(plan_rows.size(), row);
    endfunction

    function automatic void split_fields(input orbit_result_t r,
        output longint unsigned f [12]);
        f = '{r.step_clock, r.new_value, r.step_kind, r.candidate_class, r.cone_outside,
              r.cone_excess, r.current_run, r.closed_run_length, r.closed_run_start,
              r.mex_after, r.longest_run_so_far, r.status};
    endfunction

    // Idling is off for the third of every five equal stretches of the run
    function automatic bit idle_allowed();
        return ((cycle_count / 4000) % 5 != 2);
    endfunction

    // Input driver: random gap, then one beat held until accepted
    task automatic send_beat(input bit adv, input bit typed, input orbit_result_t want);
        orbit_result_t r;
        while (idle_allowed() && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        advance  <= adv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (adv)
        begin
            r = orbit_step();
            pending_results.insert(pending_results.size(), typed ? want : r);
        end
        @(negedge clk);
    endtask

    // Horizon write once the block has drained
    task automatic write_horizon(input logic [CNT_W-1:0] value);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        horizon   = value;
    endtask

    // Result checker, sampled at the rising edge
    always @(posedge clk)
    begin
        orbit_result_t got;
        orbit_result_t want;
        longint unsigned want_f [12];
        longint unsigned got_f [12];
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            got = {step_clock, new_value, step_kind, candidate_class, cone_outside,
                   cone_excess, current_run, closed_run_length, closed_run_start,
                   mex_after, longest_run_so_far, status};
            if (pending_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result beat with none expected, step_clock %0d",
                         $time, step_clock);
            end
            else
            begin
                want = pending_results.pop_front();
                split_fields(want, want_f);
                split_fields(got, got_f);
                for (int i = 0; i < 12; i++)
                begin
                    if (want_f[i] != got_f[i])
                    begin
                        mismatch_count++;
                        $display("%0t: %s expected %0d actual %0d", $time,
                                 field_names[i], want_f[i], got_f[i]);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        cycle_count++;
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Output side: random stalls plus one long hold-off to back up the input
    initial
    begin
        bit hold_done;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
                out_ready <= !(idle_allowed() && $urandom_range(99) < 31);
        end
    end

    // Stimulus
    initial
    begin
        logic [CNT_W-1:0] next_horizon;
        int stepped;
        bit adv;
        visited[0] = 1'b1;

        // First terms: 0, 1, 3, 6, 2, 7, 13, 20, 12, 21
        add_row(0, '0, 1, 1,
            known_result(1, 1, KIND_ADD, CLS_NONE, 0, 0, 1, 0, 0, 2, 1, STAT_STEP));
        add_row(0, '0, 1, 1,
            known_result(2, 3, KIND_ADD, CLS_NONE, 0, 0, 2, 0, 0, 2, 2, STAT_STEP));
        add_row(0, '0, 0, 0, '0);
        add_row(0, '0, 1, 1,
            known_result(3, 6, KIND_ADD, CLS_NONE, 0, 0, 3, 0, 0, 2, 3, STAT_STEP));
        add_row(0, '0, 1, 1,
            known_result(4, 2, KIND_SUB, CLS_EQUAL, 0, 0, 0, 3, 1, 4, 3, STAT_STEP));
        repeat (5) add_row(0, '0, 1, 0, '0);
        // horizon at its minimum: censored run of one from clock 9, then empty
        add_row(1, HORIZON_MIN, 1, 1,
            known_result(9, 21, KIND_SUB, CLS_NONE, 0, 0, 0, 1, 9, 4, 3, STAT_HORIZON));
        add_row(0, '0, 1, 1,
            known_result(9, 21, KIND_SUB, CLS_NONE, 0, 0, 0, 0, 0, 4, 3, STAT_HORIZON));
        add_row(0, '0, 0, 0, '0);
        // resume at the maximum, then stop exactly one step later
        add_row(1, HORIZON_MAX, 1, 0, '0);
        add_row(1, 31'd11, 1, 0, '0);
        add_row(0, '0, 1, 0, '0);
        add_row(1, HORIZON_MAX, 1, 0, '0);
        repeat (4) add_row(0, '0, 1, 0, '0);

        // Reset, then the block clears its bitmap with in_ready low
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan_rows[i])
        begin
            if (plan_rows[i].set_horizon)
                write_horizon(plan_rows[i].horizon_val);
            send_beat(plan_rows[i].adv, plan_rows[i].typed, plan_rows[i].want);
        end

        // Random phases: odd phases stop at a nearby horizon
        for (int p = 0; p < 8; p++)
        begin
            if (p % 2 == 1)
                next_horizon = steps_done + CNT_W'($urandom_range(0, 150));
            else
                next_horizon = CNT_W'($urandom_range(2000000000, steps_done + 1000));
            write_horizon(next_horizon);
            stepped = 0;
            while (stepped < PHASE_STEPS)
            begin
                adv = $urandom_range(99) >= 10;
                send_beat(adv, 1'b0, '0);
                if (adv)
                    stepped++;
            end
        end

        // Drain
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== recaman_orbit_stepper.f =====
rtl/rso_pkg.sv
rtl/rso_alu.sv
rtl/rso_seen_mem.sv
rtl/recaman_orbit_stepper.sv
verif/recaman_orbit_stepper_test.sv
